// ===== src/gbe_pkg.sv =====
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types, codes and constants of the gap buffer engine.
// ----------------------------------------------------------------------------
package gbe_pkg;

   localparam int GBE_CAPACITY = 1024;

   localparam int GBE_OP_W     = 3;
   localparam int GBE_DATA_W   = 8;
   localparam int GBE_AMT_W    = 10;
   localparam int GBE_STATUS_W = 2;
   localparam int GBE_LEN_W    = 10;
   localparam int GBE_CUR_W    = 10;

   // operation codes
   localparam logic [GBE_OP_W-1:0] OP_INSERT     = 3'd0;
   localparam logic [GBE_OP_W-1:0] OP_MOVE_FWD   = 3'd1;
   localparam logic [GBE_OP_W-1:0] OP_MOVE_BACK  = 3'd2;
   localparam logic [GBE_OP_W-1:0] OP_ERASE_FWD  = 3'd3;
   localparam logic [GBE_OP_W-1:0] OP_ERASE_BACK = 3'd4;
   localparam logic [GBE_OP_W-1:0] OP_READ_NEXT  = 3'd5;
   localparam logic [GBE_OP_W-1:0] OP_READ_PREV  = 3'd6;
   localparam logic [GBE_OP_W-1:0] OP_CLEAR      = 3'd7;

   // response status codes
   localparam logic [GBE_STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [GBE_STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [GBE_STATUS_W-1:0] ST_FULL  = 2'd2;

   // gap pointer update codes
   localparam logic [2:0] PTR_HOLD  = 3'd0;
   localparam logic [2:0] PTR_INS   = 3'd1;
   localparam logic [2:0] PTR_ERF   = 3'd2;
   localparam logic [2:0] PTR_ERB   = 3'd3;
   localparam logic [2:0] PTR_CLR   = 3'd4;
   localparam logic [2:0] PTR_STEPF = 3'd5;
   localparam logic [2:0] PTR_STEPB = 3'd6;

   typedef struct packed {
      logic [2:0]              ptr_op;
      logic                    dir_fwd;    // copy direction of a move
      logic                    rd_next;    // read source one beyond the current one
      logic                    ram_we;
      logic                    wr_ins;     // write the request byte at the cursor
      logic                    cnt_load;
      logic                    cnt_one;    // load a count of one (reads)
      logic                    cnt_dec;
      logic                    rsp_load;
      logic [GBE_STATUS_W-1:0] rsp_status;
      logic                    rsp_rd;     // return the copied byte
   } gbe_cmd_type;

   typedef struct packed {
      logic full;
      logic fwd_ok;
      logic back_ok;
      logic next_ok;
      logic prev_ok;
      logic amt_zero;
      logic cnt_last;
   } gbe_stat_type;

endpackage

// ===== src/gbe_if.sv =====
// ----------------------------------------------------------------------------
// gbe_if
// Valid/ready channels of the gap buffer engine: request and response.
// ----------------------------------------------------------------------------
interface gbe_req_if
   import gbe_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [GBE_OP_W-1:0]   op;
   logic [GBE_DATA_W-1:0] data_in;
   logic [GBE_AMT_W-1:0]  amount;

   modport source (output valid, output op, output data_in, output amount, input ready);
   modport sink   (input valid, input op, input data_in, input amount, output ready);
endinterface

interface gbe_rsp_if
   import gbe_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [GBE_STATUS_W-1:0] status;
   logic [GBE_DATA_W-1:0]   data_out;
   logic [GBE_LEN_W-1:0]    text_length;
   logic [GBE_CUR_W-1:0]    cursor;

   modport source (output valid, output status, output data_out, output text_length,
                   output cursor, input ready);
   modport sink   (input valid, input status, input data_out, input text_length,
                   input cursor, output ready);
endinterface

// ===== src/gbe_ram.sv =====
// ----------------------------------------------------------------------------
// gbe_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/gbe_dp.sv =====
// ----------------------------------------------------------------------------
// gbe_dp
// Datapath: gap pointers, copy counter, text store and response registers.
// ----------------------------------------------------------------------------
module gbe_dp
   import gbe_pkg::*;
#(
   parameter int CAPACITY = GBE_CAPACITY
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [GBE_DATA_W-1:0]   req_data_in,
   input  logic [GBE_AMT_W-1:0]    req_amount,
   input  gbe_cmd_type             cmd,
   output gbe_stat_type            stat,
   output logic [GBE_STATUS_W-1:0] rsp_status,
   output logic [GBE_DATA_W-1:0]   rsp_data_out,
   output logic [GBE_LEN_W-1:0]    rsp_text_length,
   output logic [GBE_CUR_W-1:0]    rsp_cursor
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = ((AW > GBE_AMT_W) ? AW : GBE_AMT_W) + 1;
   localparam logic [AW-1:0] LAST   = AW'(CAPACITY - 1);
   localparam logic [CW-1:0] LAST_W = CW'(CAPACITY - 1);

   logic [AW-1:0]           gs_ff, gs_in, ge_ff, ge_in;
   logic [GBE_AMT_W-1:0]    cnt_ff, cnt_in;
   logic [GBE_STATUS_W-1:0] status_ff;
   logic [GBE_DATA_W-1:0]   data_ff, data_in;
   logic [GBE_LEN_W-1:0]    len_ff, len_in;
   logic [GBE_CUR_W-1:0]    cur_ff, cur_in;

   logic [CW-1:0]           gs_w, ge_w, amt_w, gs_in_w, ge_in_w;
   logic [AW-1:0]           waddr, raddr;
   logic [GBE_DATA_W-1:0]   wdata, rdata;

   assign gs_w  = CW'(gs_ff);
   assign ge_w  = CW'(ge_ff);
   assign amt_w = CW'(req_amount);

   assign stat.full     = (gs_ff == ge_ff);
   assign stat.fwd_ok   = (ge_w + amt_w) <= LAST_W;
   assign stat.back_ok  = amt_w <= gs_w;
   assign stat.next_ok  = (ge_ff != LAST);
   assign stat.prev_ok  = (gs_ff != '0);
   assign stat.amt_zero = (req_amount == '0);
   assign stat.cnt_last = (cnt_ff == GBE_AMT_W'(1));

   always_comb begin
      gs_in = gs_ff;
      ge_in = ge_ff;
      case (cmd.ptr_op)
         PTR_INS:   gs_in = gs_ff + AW'(1);
         PTR_ERF:   ge_in = AW'(ge_w + amt_w);
         PTR_ERB:   gs_in = AW'(gs_w - amt_w);
         PTR_CLR: begin
            gs_in = '0;
            ge_in = LAST;
         end
         PTR_STEPF: begin
            gs_in = gs_ff + AW'(1);
            ge_in = ge_ff + AW'(1);
         end
         PTR_STEPB: begin
            gs_in = gs_ff - AW'(1);
            ge_in = ge_ff - AW'(1);
         end
         default: ;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_load) begin
         cnt_in = cmd.cnt_one ? GBE_AMT_W'(1) : req_amount;
      end else if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - GBE_AMT_W'(1);
      end
   end

   // text store: copies read the source ahead of the write
   always_comb begin
      if (cmd.dir_fwd) begin
         raddr = cmd.rd_next ? ge_ff + AW'(2) : ge_ff + AW'(1);
      end else begin
         raddr = cmd.rd_next ? gs_ff - AW'(2) : gs_ff - AW'(1);
      end
      if (cmd.wr_ins) begin
         waddr = gs_ff;
         wdata = req_data_in;
      end else begin
         waddr = cmd.dir_fwd ? gs_ff : ge_ff;
         wdata = rdata;
      end
   end

   gbe_ram #(
      .WIDTH (GBE_DATA_W),
      .DEPTH (CAPACITY)
   ) u_text_store (
      .clock (clock),
      .we    (cmd.ram_we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign gs_in_w = CW'(gs_in);
   assign ge_in_w = CW'(ge_in);
   assign len_in  = GBE_LEN_W'(gs_in_w + (LAST_W - ge_in_w));
   assign cur_in  = GBE_CUR_W'(gs_in_w);
   assign data_in = cmd.rsp_rd ? rdata : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gs_ff <= '0;
         ge_ff <= LAST;
      end else begin
         gs_ff <= gs_in;
         ge_ff <= ge_in;
      end
      cnt_ff <= cnt_in;
      if (cmd.rsp_load) begin
         status_ff <= cmd.rsp_status;
         data_ff   <= data_in;
         len_ff    <= len_in;
         cur_ff    <= cur_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_data_out    = data_ff;
   assign rsp_text_length = len_ff;
   assign rsp_cursor      = cur_ff;

endmodule

// ===== src/gbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbe_ctrl
// Controller: request decode, copy sequencing and response handshake.
// ----------------------------------------------------------------------------
module gbe_ctrl
   import gbe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [GBE_OP_W-1:0] req_op,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  gbe_stat_type        stat,
   output gbe_cmd_type         cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_MOVE = 1'b1;

   logic state_ff, state_in;
   logic dir_ff, dir_in;
   logic rdop_ff, rdop_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd         = '0;
      cmd.dir_fwd = dir_ff;
      state_in    = state_ff;
      dir_in      = dir_ff;
      rdop_in     = rdop_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_OK;
               unique case (req_op)
                  OP_INSERT: begin
                     if (stat.full) begin
                        cmd.rsp_status = ST_FULL;
                     end else begin
                        cmd.ptr_op = PTR_INS;
                        cmd.ram_we = 1'b1;
                        cmd.wr_ins = 1'b1;
                     end
                  end
                  OP_MOVE_FWD, OP_MOVE_BACK: begin
                     if ((req_op == OP_MOVE_FWD) ? !stat.fwd_ok : !stat.back_ok) begin
                        cmd.rsp_status = ST_RANGE;
                     end else if (!stat.amt_zero) begin
                        // first source byte is read now, copies follow
                        cmd.rsp_load = 1'b0;
                        cmd.cnt_load = 1'b1;
                        cmd.dir_fwd  = (req_op == OP_MOVE_FWD);
                        dir_in       = (req_op == OP_MOVE_FWD);
                        rdop_in      = 1'b0;
                        state_in     = ST_MOVE;
                     end
                  end
                  OP_READ_NEXT, OP_READ_PREV: begin
                     if ((req_op == OP_READ_NEXT) ? !stat.next_ok : !stat.prev_ok) begin
                        cmd.rsp_status = ST_RANGE;
                     end else begin
                        // a read is a one-byte move that returns the byte
                        cmd.rsp_load = 1'b0;
                        cmd.cnt_load = 1'b1;
                        cmd.cnt_one  = 1'b1;
                        cmd.dir_fwd  = (req_op == OP_READ_NEXT);
                        dir_in       = (req_op == OP_READ_NEXT);
                        rdop_in      = 1'b1;
                        state_in     = ST_MOVE;
                     end
                  end
                  OP_ERASE_FWD: begin
                     if (stat.fwd_ok) begin
                        cmd.ptr_op = PTR_ERF;
                     end else begin
                        cmd.rsp_status = ST_RANGE;
                     end
                  end
                  OP_ERASE_BACK: begin
                     if (stat.back_ok) begin
                        cmd.ptr_op = PTR_ERB;
                     end else begin
                        cmd.rsp_status = ST_RANGE;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.ptr_op = PTR_CLR;
                  end
                  default: ;
               endcase
            end
         end
         ST_MOVE: begin
            cmd.ram_we  = 1'b1;
            cmd.ptr_op  = dir_ff ? PTR_STEPF : PTR_STEPB;
            cmd.cnt_dec = 1'b1;
            cmd.rd_next = 1'b1;
            if (stat.cnt_last) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_OK;
               cmd.rsp_rd     = rdop_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dir_ff       <= 1'b0;
         rdop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dir_ff       <= dir_in;
         rdop_ff      <= rdop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/gap_buffer_engine_unit.sv =====
// ----------------------------------------------------------------------------
// gap_buffer_engine_unit
// Fixed-capacity gap buffer for text bytes with cursor edit operations.
//
//   channel   dir  payload                                  handshake
//   req_chan  in   op, data_in, amount                      valid/ready
//   rsp_chan  out  status, data_out, text_length, cursor    valid/ready
//
// Insert, erase, clear and rejected requests load the response register when
// taken. A move of n bytes reads a byte ahead, then copies one byte per cycle
// through the text store's read and write ports; read next/previous is a
// one-byte move that returns the byte. Reset sets the cursor to 0 and the gap
// to the whole store; text bytes are not cleared. A request is taken once no
// move runs and the response register is free or drained in the same cycle.
// ----------------------------------------------------------------------------
module gap_buffer_engine_unit
   import gbe_pkg::*;
#(
   parameter int CAPACITY = GBE_CAPACITY
) (
   input  logic      clock,
   input  logic      reset,
   gbe_req_if.sink   req_chan,
   gbe_rsp_if.source rsp_chan
);

   gbe_cmd_type  cmd;
   gbe_stat_type stat;

   gbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gbe_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_data_in     (req_chan.data_in),
      .req_amount      (req_chan.amount),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_chan.status),
      .rsp_data_out    (rsp_chan.data_out),
      .rsp_text_length (rsp_chan.text_length),
      .rsp_cursor      (rsp_chan.cursor)
   );

endmodule

// ===== tb/tb_gap_buffer_engine_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gap_buffer_engine_unit
// Self-checking bench for the gap buffer engine. A short table of edits runs
// first (boundary, error and empty-buffer cases), then random edit traffic.
// Every response is compared against a hand-written value or an in-bench model
// of the text store and gap pointers, with random idle cycles on both channels
// and one long response stall.
// ----------------------------------------------------------------------------
module tb_gap_buffer_engine_unit;
   import gbe_pkg::*;

   localparam int RAND_ITEMS  = 378;
   localparam int PRESSURE_AT = 300;       // responses seen before the long stall
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 5000000;
   localparam int LAST_IDX    = GBE_CAPACITY - 1;

   typedef struct packed {
      logic [GBE_STATUS_W-1:0] status;
      logic [GBE_DATA_W-1:0]   data_out;
      logic [GBE_LEN_W-1:0]    text_length;
      logic [GBE_CUR_W-1:0]    cursor;
   } edit_result_type;

   typedef struct packed {
      logic [GBE_OP_W-1:0]   op;
      logic [GBE_DATA_W-1:0] din;
      logic [GBE_AMT_W-1:0]  amt;
      logic                  typed;      // want holds a hand-written response
      edit_result_type       want;
   } edit_row_type;

   logic clock = 1'b0;
   logic reset;

   gbe_req_if req_chan ();
   gbe_rsp_if rsp_chan ();

   gap_buffer_engine_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // model of the text store and gap
   logic [GBE_DATA_W-1:0] text_mem [GBE_CAPACITY];
   int                    gap_lo;
   int                    gap_hi;

   edit_result_type edit_results_q [$];
   edit_row_type    dir_tab [$];

   int  mismatches   = 0;
   int  results_seen = 0;
   int  cycles       = 0;
   int  hold_cnt     = 0;
   bit  pressure_done = 1'b0;
   bit  free_run     = 1'b0;

   function automatic void step_fwd();
      text_mem[gap_lo] = text_mem[gap_hi + 1];
      gap_lo++;
      gap_hi++;
   endfunction

   function automatic void step_back();
      text_mem[gap_hi] = text_mem[gap_lo - 1];
      gap_lo--;
      gap_hi--;
   endfunction

   function automatic edit_result_type apply_edit(input logic [GBE_OP_W-1:0] op,
                                                  input logic [GBE_DATA_W-1:0] din,
                                                  input logic [GBE_AMT_W-1:0] amt);
      edit_result_type r;
      int              n;
      r.status   = ST_OK;
      r.data_out = '0;
      case (op)
         OP_INSERT: begin
            if (gap_lo == gap_hi) begin
               r.status = ST_FULL;
            end else begin
               text_mem[gap_lo] = din;
               gap_lo++;
            end
         end
         OP_MOVE_FWD: begin
            if (gap_hi + int'(amt) > LAST_IDX) r.status = ST_RANGE;
            else for (n = 0; n < int'(amt); n++) step_fwd();
         end
         OP_MOVE_BACK: begin
            if (int'(amt) > gap_lo) r.status = ST_RANGE;
            else for (n = 0; n < int'(amt); n++) step_back();
         end
         OP_ERASE_FWD: begin
            if (gap_hi + int'(amt) > LAST_IDX) r.status = ST_RANGE;
            else gap_hi += int'(amt);
         end
         OP_ERASE_BACK: begin
            if (int'(amt) > gap_lo) r.status = ST_RANGE;
            else gap_lo -= int'(amt);
         end
         OP_READ_NEXT: begin
            if (gap_hi + 1 > LAST_IDX) begin
               r.status = ST_RANGE;
            end else begin
               r.data_out = text_mem[gap_hi + 1];
               step_fwd();
            end
         end
         OP_READ_PREV: begin
            if (gap_lo < 1) begin
               r.status = ST_RANGE;
            end else begin
               r.data_out = text_mem[gap_lo - 1];
               step_back();
            end
         end
         OP_CLEAR: begin
            gap_lo = 0;
            gap_hi = LAST_IDX;
         end
      endcase
      r.text_length = GBE_LEN_W'(GBE_CAPACITY - (gap_hi - gap_lo + 1));
      r.cursor      = GBE_CUR_W'(gap_lo);
      return r;
   endfunction

   // mostly in range and small, some just past the limit, some anywhere
   function automatic logic [GBE_AMT_W-1:0] pick_amount(input int room);
      int r;
      int lim;
      r = $urandom_range(0, 99);
      if (r < 10 && room < LAST_IDX) begin
         lim = (room + 8 > LAST_IDX) ? LAST_IDX : room + 8;
         return GBE_AMT_W'($urandom_range(room + 1, lim));
      end else if (r < 16) begin
         return GBE_AMT_W'($urandom_range(0, LAST_IDX));
      end
      lim = (room < 12) ? room : 12;
      return GBE_AMT_W'($urandom_range(0, lim));
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic edit_row_type make_row(input logic [GBE_OP_W-1:0] op,
                                             input logic [GBE_DATA_W-1:0] din,
                                             input logic [GBE_AMT_W-1:0] amt,
                                             input logic typed,
                                             input logic [GBE_STATUS_W-1:0] st,
                                             input logic [GBE_DATA_W-1:0] dout,
                                             input logic [GBE_LEN_W-1:0] len,
                                             input logic [GBE_CUR_W-1:0] cur);
      edit_row_type row;
      row.op                 = op;
      row.din                = din;
      row.amt                = amt;
      row.typed              = typed;
      row.want.status        = st;
      row.want.data_out      = dout;
      row.want.text_length   = len;
      row.want.cursor        = cur;
      return row;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch at response %0d: %s got %h want %h",
               results_seen, what, got, want);
      mismatches++;
   endtask

   task automatic send_edit(input logic [GBE_OP_W-1:0] op, input logic [GBE_DATA_W-1:0] din,
                            input logic [GBE_AMT_W-1:0] amt, input logic typed,
                            input edit_result_type want);
      edit_result_type pred;
      int              gap;
      req_chan.valid   <= 1'b1;
      req_chan.op      <= op;
      req_chan.data_in <= din;
      req_chan.amount  <= amt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pred = apply_edit(op, din, amt);
      edit_results_q.push_back(typed ? want : pred);
      gap = free_run ? 0 : idle_len();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response side: check, then pick next ready
   always @(posedge clock) begin
      edit_result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready) begin
         if (edit_results_q.size() == 0) begin
            report_mismatch("transaction with none pending", 16'(rsp_chan.cursor), 16'h0);
         end else begin
            want = edit_results_q.pop_front();
            if (rsp_chan.status !== want.status)
               report_mismatch("status", 16'(rsp_chan.status), 16'(want.status));
            if (rsp_chan.data_out !== want.data_out)
               report_mismatch("data_out", 16'(rsp_chan.data_out), 16'(want.data_out));
            if (rsp_chan.text_length !== want.text_length)
               report_mismatch("text_length", 16'(rsp_chan.text_length),
                               16'(want.text_length));
            if (rsp_chan.cursor !== want.cursor)
               report_mismatch("cursor", 16'(rsp_chan.cursor), 16'(want.cursor));
         end
         results_seen++;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_chan.ready <= 1'b0;
      end else if (!pressure_done && results_seen == PRESSURE_AT) begin
         // long back-pressure while the sender keeps offering
         pressure_done = 1'b1;
         hold_cnt = HOLD_CYCLES - 1;
         rsp_chan.ready <= 1'b0;
      end else if (free_run) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         hold_cnt = idle_len();
         if (hold_cnt == 0) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            hold_cnt--;
            rsp_chan.ready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int                    k;
      int                    sel;
      logic [GBE_OP_W-1:0]   op;
      logic [GBE_DATA_W-1:0] din;
      logic [GBE_AMT_W-1:0]  amt;

      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.op      = OP_INSERT;
      req_chan.data_in = '0;
      req_chan.amount  = '0;
      rsp_chan.ready   = 1'b0;
      gap_lo = 0;
      gap_hi = LAST_IDX;

      // empty buffer errors, zero amounts, inserts, then moves, reads, erases and clear
      dir_tab.push_back(make_row(OP_READ_PREV,  8'h00, 10'd0,    1'b1, ST_RANGE, 8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_READ_NEXT,  8'hFF, 10'd1023, 1'b1, ST_RANGE, 8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_MOVE_BACK,  8'h00, 10'd1,    1'b1, ST_RANGE, 8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_MOVE_FWD,   8'h00, 10'd1,    1'b1, ST_RANGE, 8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_ERASE_BACK, 8'h00, 10'd1023, 1'b1, ST_RANGE, 8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_ERASE_FWD,  8'h00, 10'd1023, 1'b1, ST_RANGE, 8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_MOVE_FWD,   8'h00, 10'd0,    1'b1, ST_OK,    8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_ERASE_BACK, 8'h00, 10'd0,    1'b1, ST_OK,    8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_INSERT,     8'h00, 10'd1023, 1'b1, ST_OK,    8'h00,
                                 10'd1, 10'd1));
      dir_tab.push_back(make_row(OP_INSERT,     8'hFF, 10'd0,    1'b1, ST_OK,    8'h00,
                                 10'd2, 10'd2));
      dir_tab.push_back(make_row(OP_INSERT,     8'hA5, 10'd0,    1'b1, ST_OK,    8'h00,
                                 10'd3, 10'd3));
      dir_tab.push_back(make_row(OP_MOVE_BACK,  8'h00, 10'd2,    1'b0, ST_OK,    8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_READ_NEXT,  8'h00, 10'd0,    1'b0, ST_OK,    8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_READ_PREV,  8'h00, 10'd0,    1'b0, ST_OK,    8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_ERASE_FWD,  8'h00, 10'd1,    1'b0, ST_OK,    8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_MOVE_FWD,   8'h00, 10'd1,    1'b0, ST_OK,    8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_READ_NEXT,  8'h00, 10'd0,    1'b0, ST_OK,    8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_ERASE_BACK, 8'h00, 10'd2,    1'b0, ST_OK,    8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_INSERT,     8'h5A, 10'd0,    1'b0, ST_OK,    8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_CLEAR,      8'hFF, 10'd1023, 1'b1, ST_OK,    8'h00,
                                 10'd0, 10'd0));
      // stale bytes must not show after clear
      dir_tab.push_back(make_row(OP_READ_NEXT,  8'h00, 10'd0,    1'b1, ST_RANGE, 8'h00,
                                 10'd0, 10'd0));
      dir_tab.push_back(make_row(OP_MOVE_BACK,  8'h00, 10'd1023, 1'b1, ST_RANGE, 8'h00,
                                 10'd0, 10'd0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         send_edit(dir_tab[i].op, dir_tab[i].din, dir_tab[i].amt, dir_tab[i].typed,
                   dir_tab[i].want);

      for (k = 0; k < RAND_ITEMS; k++) begin
         free_run = (k >= 60 && k < 120);
         sel = $urandom_range(0, 99);
         din = 8'($urandom_range(0, 255));
         if (sel < 34)      op = OP_INSERT;
         else if (sel < 44) op = OP_MOVE_FWD;
         else if (sel < 54) op = OP_MOVE_BACK;
         else if (sel < 61) op = OP_ERASE_FWD;
         else if (sel < 68) op = OP_ERASE_BACK;
         else if (sel < 78) op = OP_READ_NEXT;
         else if (sel < 88) op = OP_READ_PREV;
         else if (sel < 91) op = OP_CLEAR;
         else               op = GBE_OP_W'($urandom_range(0, 7));
         case (op)
            OP_MOVE_FWD, OP_ERASE_FWD:   amt = pick_amount(LAST_IDX - gap_hi);
            OP_MOVE_BACK, OP_ERASE_BACK: amt = pick_amount(gap_lo);
            default:                     amt = GBE_AMT_W'($urandom_range(0, 1023));
         endcase
         send_edit(op, din, amt, 1'b0, '0);
      end
      free_run = 1'b0;
      req_chan.valid <= 1'b0;

      while (edit_results_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatches == 0 && edit_results_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
